[hw/rtl/cs_pkg.sv]
// ----------------------------------------------------------------------------
// cs_pkg: shared widths, codes and command types of the cosine similarity block
// widths follow from the longest vector for which the accumulators are exact
// ----------------------------------------------------------------------------
package cs_pkg;

    localparam int MAX_LEN    = 4096;
    localparam int ELEM_W     = 16;
    // one square is at most 2^30, summed over MAX_LEN pairs
    localparam int SQ_W       = 2 * ELEM_W - 1 + $clog2(MAX_LEN);
    localparam int DOT_W      = SQ_W + 1;
    localparam int PROD_W     = 2 * SQ_W;
    // operand halves for the split wide multiply
    localparam int LO_W       = (SQ_W + 1) / 2;
    localparam int HI_W       = SQ_W - LO_W;
    localparam int PP_W       = 2 * LO_W;
    localparam int ROOT_W     = SQ_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int DREM_W     = ROOT_W + 1;
    localparam int Q_W        = ELEM_W;
    localparam int MUL_STEPS  = 4;
    localparam int SQRT_STEPS = PROD_W / 2;
    localparam int CNT_W      = $clog2(SQRT_STEPS + 1);

    localparam logic [ELEM_W-1:0] SIM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] SIM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    // partial product shift codes, in units of LO_W bits
    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_ONE  = 2'd1;
    localparam logic [1:0] SH_TWO  = 2'd2;

    typedef struct packed {
        logic       acc_en;
        logic       acc_clr;
        logic       prod_clr;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       add_en;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } t_cs_cmd;

    typedef struct packed {
        logic zero_norm;
        logic out_free;
    } t_cs_sts;

endpackage

[hw/rtl/cosine_similarity.sv]
// ----------------------------------------------------------------------------
// cosine_similarity: streamed fixed point cosine similarity of two vectors
// element pairs in, one saturated q1.15 similarity per vector out
// ----------------------------------------------------------------------------
// element pairs arrive one per transaction and are accumulated at one pair a
// clock, while the sequencer is idle, into a dot product and two sums of
// squares; the pair with tlast set closes the vector and the engine takes
// over in the next cycle: a four step split multiply of the two sums of
// squares, a bit-pair floor square root of that 86-bit product and a
// restoring divider that yields the 16 quotient bits plus an overflow test,
// then the result is written to the output register. no further pair is taken
// until the result is written; when either sum of squares is zero the multiply,
// root and divide are skipped and the result is 0 with the zero-norm flag set.
// the output register lets the next vector start while a result waits; a
// finished result waits for the output to drain.
// vectors longer than 4096 pairs may wrap the accumulators
// ----------------------------------------------------------------------------
module cosine_similarity
    import cs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] elem_a, [31:16] elem_b
    input  logic        s_axis_tlast,   // last element pair of the vectors
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] similarity
    output logic [0:0]  m_axis_tuser    // [0] zero_norm
);

    t_cs_cmd cmd;
    t_cs_sts sts;

    // sequencer: owns the input handshake and steps the engine
    cs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: accumulators, arithmetic units and the output register
    cs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem_a     (s_axis_tdata[ELEM_W-1:0]),
        .i_elem_b     (s_axis_tdata[2*ELEM_W-1:ELEM_W]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_similarity (m_axis_tdata),
        .o_zero_norm  (m_axis_tuser[0])
    );

endmodule

[hw/rtl/cs_ctrl.sv]
// ----------------------------------------------------------------------------
// cs_ctrl: sequencer of the cosine similarity block
// accumulates pairs, then steps multiply, square root and division to a result
// ----------------------------------------------------------------------------
module cs_ctrl
    import cs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    input  t_cs_sts i_sts,
    output t_cs_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SQRT  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.acc_en = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = ST_MUL;
                    n_cnt   = '0;
                end
            end
            ST_MUL: begin
                if (r_cnt == '0 && i_sts.zero_norm) begin
                    n_state = ST_WRITE;
                end else begin
                    o_cmd.mul_en   = (r_cnt < CNT_W'(MUL_STEPS));
                    o_cmd.mul_sel  = r_cnt[1:0];
                    o_cmd.add_en   = (r_cnt != '0);
                    o_cmd.prod_clr = (r_cnt == '0);
                    if (r_cnt == CNT_W'(MUL_STEPS)) begin
                        n_state = ST_SQRT;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DIV: begin
                o_cmd.div_init = (r_cnt == '0);
                o_cmd.div_step = (r_cnt != '0);
                if (r_cnt == CNT_W'(Q_W)) begin
                    n_state = ST_WRITE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.acc_clr  = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_block_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_last) |=> !o_in_ready)
        else $error("pair taken while a result is being computed");

    a_load_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after a result");

    a_state_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state <= ST_WRITE))
        else $error("sequencer in an unused state");
`endif

endmodule

[hw/rtl/cs_dp.sv]
// ----------------------------------------------------------------------------
// cs_dp: datapath of the cosine similarity block
// accumulators, split wide multiply, bit-pair square root, restoring divider
// ----------------------------------------------------------------------------
module cs_dp
    import cs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ELEM_W-1:0] i_elem_a,
    input  logic [ELEM_W-1:0] i_elem_b,
    input  t_cs_cmd           i_cmd,
    output t_cs_sts           o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ELEM_W-1:0] o_similarity,
    output logic              o_zero_norm
);

    logic [DOT_W-1:0]  r_dot;
    logic [SQ_W-1:0]   r_sqa, r_sqb;
    logic [PP_W-1:0]   r_pp;
    logic [1:0]        r_pp_sh;
    logic [PROD_W-1:0] r_prod;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rem;
    logic [DREM_W-1:0] r_drem;
    logic [Q_W-1:0]    r_q;
    logic              r_ovf;
    logic              r_out_valid;
    logic [ELEM_W-1:0] r_sim;
    logic              r_zn;

    logic signed [2*ELEM_W-1:0] ab, aa, bb;
    logic [LO_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0] pp_sh;
    logic [REM_W-1:0]  s_t, s_trial;
    logic              s_ge;
    logic [ROOT_W-1:0] den;
    logic [DOT_W-1:0]  mag;
    logic [DREM_W-1:0] d_t;
    logic              d_ge;
    logic              neg;
    logic [ELEM_W-1:0] sim;

    assign ab = $signed(i_elem_a) * $signed(i_elem_b);
    assign aa = $signed(i_elem_a) * $signed(i_elem_a);
    assign bb = $signed(i_elem_b) * $signed(i_elem_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.acc_clr) begin
            r_dot <= '0;
            r_sqa <= '0;
            r_sqb <= '0;
        end else if (i_cmd.acc_en) begin
            r_dot <= r_dot + DOT_W'(ab);
            r_sqa <= r_sqa + SQ_W'(aa[2*ELEM_W-2:0]);
            r_sqb <= r_sqb + SQ_W'(bb[2*ELEM_W-2:0]);
        end
    end

    assign o_sts.zero_norm = (r_sqa == '0) || (r_sqb == '0);

    // wide product in four partial products, one multiply a cycle
    assign mul_a = i_cmd.mul_sel[1] ? LO_W'(r_sqa[SQ_W-1:LO_W]) : r_sqa[LO_W-1:0];
    assign mul_b = i_cmd.mul_sel[0] ? LO_W'(r_sqb[SQ_W-1:LO_W]) : r_sqb[LO_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_pp    <= PP_W'(mul_a) * PP_W'(mul_b);
            r_pp_sh <= 2'(i_cmd.mul_sel[0]) + 2'(i_cmd.mul_sel[1]);
        end
    end

    always_comb begin
        unique case (r_pp_sh)
            SH_NONE: pp_sh = PROD_W'(r_pp);
            SH_ONE:  pp_sh = PROD_W'(r_pp) << LO_W;
            SH_TWO:  pp_sh = PROD_W'(r_pp) << (2 * LO_W);
            default: pp_sh = '0;
        endcase
    end

    // square root, two radicand bits a step
    assign s_t     = {r_rem[REM_W-3:0], r_prod[PROD_W-1:PROD_W-2]};
    assign s_trial = {r_root, 2'b01};
    assign s_ge    = (s_t >= s_trial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod_clr) begin
            r_prod <= '0;
            r_root <= '0;
            r_rem  <= '0;
        end else if (i_cmd.add_en) begin
            r_prod <= r_prod + pp_sh;
        end else if (i_cmd.sqrt_step) begin
            r_prod <= r_prod << 2;
            r_rem  <= s_ge ? (s_t - s_trial) : s_t;
            r_root <= {r_root[ROOT_W-2:0], s_ge};
        end
    end

    // restoring division of |dot| * 2^15 by the root, quotient bits only
    assign den  = (r_root == '0) ? ROOT_W'(1) : r_root;
    assign neg  = r_dot[DOT_W-1];
    assign mag  = neg ? (~r_dot + 1'b1) : r_dot;
    assign d_t  = {r_drem[DREM_W-2:0], r_q[Q_W-1]};
    assign d_ge = (d_t >= {1'b0, den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_ovf  <= ({1'b0, mag[DOT_W-1:1]} >= {1'b0, den});
            r_drem <= {1'b0, mag[DOT_W-1:1]};
            r_q    <= {mag[0], {(Q_W-1){1'b0}}};
        end else if (i_cmd.div_step) begin
            r_drem <= d_ge ? (d_t - {1'b0, den}) : d_t;
            r_q    <= {r_q[Q_W-2:0], d_ge};
        end
    end

    always_comb begin
        if (neg) begin
            sim = (r_ovf || r_q > SIM_MIN) ? SIM_MIN : (~r_q + 1'b1);
        end else begin
            sim = (r_ovf || r_q[Q_W-1]) ? SIM_MAX : r_q;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_sim <= o_sts.zero_norm ? '0 : sim;
            r_zn  <= o_sts.zero_norm;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_similarity   = r_sim;
    assign o_zero_norm    = r_zn;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote one not yet taken");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc_clr |=> (r_dot == '0 && r_sqa == '0 && r_sqb == '0))
        else $error("accumulators not cleared after a result");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.sqrt_step && (i_cmd.div_step || i_cmd.div_init || i_cmd.add_en)))
        else $error("square root overlaps another unit");
`endif

endmodule

[tb/sv/tb_cosine_similarity.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cosine_similarity: self-checking bench for the cosine similarity block
// streams element pairs through the slave side and scores every similarity
// on the master side against a bit-exact predictor. a directed table comes
// first, then three random phases with different idling on each side
// ----------------------------------------------------------------------------
module tb_cosine_similarity;
    import cs_pkg::*;

    // no transaction on either side for this many cycles ends the run
    localparam int STALL_LIMIT  = 20000;
    // extra cycles run after the last expected result
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_PAIRS  = 400;
    localparam int N_DIRECTED   = 21;

    typedef struct packed {
        logic signed [ELEM_W-1:0] sim;
        logic                     zero_norm;
    } t_sim_result;

    // one element pair, with a hand-worked result where it is obvious
    typedef struct packed {
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        logic                     lst;
        logic                     typed;
        t_sim_result              res;
    } t_pair_row;

    typedef enum int {
        FL_FULL,
        FL_EXTREME,
        FL_SMALL,
        FL_ALIGNED,
        FL_ONE_SIDED
    } t_flavour;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [15:0] elem_a, [31:16] elem_b
    logic        s_axis_tlast = 1'b0;  // last element pair of the vectors
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [15:0] similarity
    logic [0:0]  m_axis_tuser;         // [0] zero_norm

    // predictor state, mirrors the block's accumulators
    logic [DOT_W-1:0] dot_sum = '0;
    logic [SQ_W-1:0]  sq_a_sum = '0;
    logic [SQ_W-1:0]  sq_b_sum = '0;

    t_sim_result similarity_q[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          pairs_sent = 0;
    int          stall_cycles = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;

    cosine_similarity uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_pair_row pair_row(input int a, input int b, input bit lst,
                                           input bit typed, input int sim, input bit zn);
        t_pair_row row;
        row.a             = ELEM_W'(a);
        row.b             = ELEM_W'(b);
        row.lst           = lst;
        row.typed         = typed;
        row.res.sim       = ELEM_W'(sim);
        row.res.zero_norm = zn;
        return row;
    endfunction

    // directed table: zero norms, full-scale pairs, orthogonal and mixed vectors
    t_pair_row directed_rows [N_DIRECTED] = '{
        pair_row(0, 0, 1, 1, 0, 1),                 // straight after reset, zero norm
        pair_row(1, 0, 1, 1, 0, 1),                 // second vector zero
        pair_row(0, -32768, 1, 1, 0, 1),            // first vector zero
        pair_row(32767, 32767, 1, 1, 32767, 0),     // ratio of one clamps high
        pair_row(-32768, -32768, 1, 1, 32767, 0),
        pair_row(-32768, 32767, 1, 1, -32768, 0),   // exactly minus one
        pair_row(1, -1, 1, 1, -32768, 0),           // smallest norms
        pair_row(32767, -32767, 1, 1, -32768, 0),   // opposite full-scale pair
        pair_row(1, 0, 0, 0, 0, 0),
        pair_row(0, 1, 1, 1, 0, 0),                 // orthogonal, similarity zero
        pair_row(0, 5, 0, 0, 0, 0),
        pair_row(0, -7, 1, 1, 0, 1),                // zero norm over several pairs
        pair_row(12345, -23456, 0, 0, 0, 0),
        pair_row(-32768, 32767, 0, 0, 0, 0),
        pair_row(32767, -1, 0, 0, 0, 0),
        pair_row(-1, 32767, 1, 0, 0, 0),
        pair_row(-32768, 1, 0, 0, 0, 0),
        pair_row(32767, -32768, 1, 0, 0, 0),
        pair_row(21845, -10923, 1, 0, 0, 0),        // single pair, mid values
        pair_row(-12000, -12000, 0, 0, 0, 0),
        pair_row(12000, 12000, 1, 1, 32767, 0)      // identical vectors
    };

    // floor square root, one result bit per pass from the top
    function automatic logic [SQ_W-1:0] floor_root(input logic [2*SQ_W-1:0] n);
        logic [SQ_W-1:0]   root;
        logic [SQ_W-1:0]   trial;
        logic [2*SQ_W-1:0] trial_sq;
        root = '0;
        for (int k = SQ_W - 1; k >= 0; k--) begin
            trial    = root | (SQ_W'(1) << k);
            trial_sq = trial * trial;
            if (trial_sq <= n)
                root = trial;
        end
        return root;
    endfunction

    // folds one pair into the sums; on the last pair yields the similarity
    function automatic bit fold_pair(input logic signed [ELEM_W-1:0] a,
                                     input logic signed [ELEM_W-1:0] b,
                                     input logic lst, output t_sim_result res);
        logic signed [31:0] p_ab;
        logic signed [31:0] p_aa;
        logic signed [31:0] p_bb;
        logic [2*SQ_W-1:0]  norm_prod;
        logic [SQ_W-1:0]    root;
        logic [DOT_W-1:0]   mag;
        logic [63:0]        quot;
        logic               neg;
        res  = '0;
        p_ab = a * b;
        p_aa = a * a;
        p_bb = b * b;
        dot_sum  = dot_sum + {{(DOT_W-32){p_ab[31]}}, p_ab};
        sq_a_sum = sq_a_sum + {{(SQ_W-31){1'b0}}, p_aa[30:0]};
        sq_b_sum = sq_b_sum + {{(SQ_W-31){1'b0}}, p_bb[30:0]};
        if (!lst)
            return 1'b0;
        if (sq_a_sum == '0 || sq_b_sum == '0) begin
            res.zero_norm = 1'b1;
        end else begin
            norm_prod = sq_a_sum * sq_b_sum;
            root      = floor_root(norm_prod);
            if (root == '0)
                root = SQ_W'(1);
            neg  = dot_sum[DOT_W-1];
            mag  = neg ? -dot_sum : dot_sum;
            // magnitude in q2.30 scaled by 2^15, truncated toward zero
            quot = {{(64-DOT_W-15){1'b0}}, mag, 15'b0} / {{(64-SQ_W){1'b0}}, root};
            if (neg) begin
                if (quot > 64'd32768)
                    quot = 64'd32768;
                res.sim = -quot[ELEM_W-1:0];
            end else begin
                if (quot > 64'd32767)
                    quot = 64'd32767;
                res.sim = quot[ELEM_W-1:0];
            end
        end
        dot_sum  = '0;
        sq_a_sum = '0;
        sq_b_sum = '0;
        return 1'b1;
    endfunction

    function automatic logic signed [ELEM_W-1:0] random_elem(input t_flavour fl);
        case (fl)
            FL_EXTREME: begin
                case ($urandom_range(5))
                    0: return ELEM_W'(-32768);
                    1: return ELEM_W'(-32767);
                    2: return ELEM_W'(-1);
                    3: return ELEM_W'(0);
                    4: return ELEM_W'(1);
                    default: return ELEM_W'(32767);
                endcase
            end
            FL_SMALL: return ELEM_W'(int'($urandom_range(32)) - 16);
            default:  return ELEM_W'($urandom);
        endcase
    endfunction

    // mostly short vectors so the engine's per-vector cost shows up often
    function automatic int vector_len();
        if ($urandom_range(9) < 7)
            return int'($urandom_range(8, 1));
        return int'($urandom_range(48, 9));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s, result %0d: got %0d, expected %0d",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    // one slave-side transaction; called and left at a falling edge
    task automatic send_pair(input t_pair_row row);
        t_sim_result predicted;
        t_sim_result queued;
        while (int'($urandom_range(99)) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row.b, row.a};
        s_axis_tlast  <= row.lst;
        do @(posedge i_clk); while (!s_axis_tready);
        if (fold_pair(row.a, row.b, row.lst, predicted)) begin
            queued = row.typed ? row.res : predicted;
            similarity_q.insert(similarity_q.size(), queued);
        end
        pairs_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_vector(input int len);
        t_pair_row row;
        t_flavour  fl;
        bit        zero_a;
        fl     = t_flavour'($urandom_range(4));
        zero_a = $urandom_range(1);
        row    = '0;
        for (int i = 0; i < len; i++) begin
            row.a = random_elem(fl);
            row.b = random_elem(fl);
            case (fl)
                // near plus or minus one, where the clamp bites
                FL_ALIGNED: begin
                    case ($urandom_range(2))
                        0: row.b = row.a;
                        1: row.b = -row.a;
                        default: row.b = row.a + ELEM_W'(int'($urandom_range(6)) - 3);
                    endcase
                end
                FL_ONE_SIDED: begin
                    if (zero_a)
                        row.a = '0;
                    else
                        row.b = '0;
                end
                default: ;
            endcase
            row.lst = (i == len - 1);
            send_pair(row);
        end
    endtask

    task automatic random_phase(input int src_pct, input int snk_pct);
        int first;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        first        = pairs_sent;
        while (pairs_sent - first < PHASE_PAIRS)
            send_random_vector(vector_len());
    endtask

    // master side back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        m_axis_tready <= (int'($urandom_range(99)) >= snk_idle_pct);
    end

    // score every master-side transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_sim_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (similarity_q.size() == 0) begin
                report_mismatch("unexpected similarity", int'(signed'(m_axis_tdata)), 0);
            end else begin
                want = similarity_q.pop_front();
                if (m_axis_tdata !== want.sim)
                    report_mismatch("similarity", int'(signed'(m_axis_tdata)),
                                    int'(want.sim));
                if (m_axis_tuser[0] !== want.zero_norm)
                    report_mismatch("zero_norm", int'(m_axis_tuser[0]),
                                    int'(want.zero_norm));
            end
            results_seen++;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            send_pair(directed_rows[i]);

        // sender seldom idle, receiver mostly stalled, then the reverse
        random_phase(20, 72);
        random_phase(72, 20);

        // no idling on either side
        random_phase(0, 0);

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (similarity_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && similarity_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
